>>> rtl/raycast_wall_texture_column_macros.svh
// Assertion macros shared by the checker files of the wall texture column block.
// Depends on nothing; included by the checker module.
`ifndef RAYCAST_WALL_TEXTURE_COLUMN_MACROS_SVH
`define RAYCAST_WALL_TEXTURE_COLUMN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RWTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RWTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/rwtc_pkg.sv
// Shared types and constants of the wall texture column address generator.
// Depends on nothing; imported by every module of the block.
package rwtc_pkg;

   localparam int TEX_SIZE_DEFAULT = 64;
   localparam int SCREEN_HEIGHT    = 512;
   localparam int ROW_W            = 10;
   localparam int OFF_W            = 17;

   // Opcodes of an input item.
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Hit sides.
   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   // Wall texture codes.
   localparam logic [1:0] TEX_SOUTH = 2'd0;
   localparam logic [1:0] TEX_NORTH = 2'd1;
   localparam logic [1:0] TEX_WEST  = 2'd2;
   localparam logic [1:0] TEX_EAST  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_POSITION
   } ctrl_state_type;

   typedef struct packed {
      logic load;      // capture the geometry of a new column
      logic div_step;  // one restoring-divide iteration
      logic pos_load;  // form the start texture position
      logic emit;      // produce one pixel into the output register
      logic rsp_pop;   // the output register is taken downstream
   } cmd_type;

   typedef struct packed {
      logic active;    // a column has rows left
      logic rsp_full;  // the output register holds an item
   } status_type;

endpackage

>>> rtl/raycast_wall_texture_column.sv
// Top level of the raycaster wall texture column address generator.
// Depends on rwtc_pkg, rwtc_ctrl and rwtc_datapath.
//
//   Channel   Direction  Handshake               Carries
//   req_*     in         req_valid / req_stall   opcode plus column geometry
//   rsp_*     out        rsp_valid / rsp_stall   one pixel: row, texture, texel
//
// Step items stream pixels at one per clock while the output register is
// being drained.
// A begin item holds off the input while the step divide runs, one bit of the
// step divide per cycle, and then while the start position multiply is formed.
// Reset is synchronous and active high; it empties the column and the output.
// A stall on the result side holds the pending pixel and stalls the input.
module raycast_wall_texture_column
   import rwtc_pkg::*;
#(
   parameter int TEX_SIZE = TEX_SIZE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic               req_hit_side,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [15:0]        req_wall_dist,
   input  logic [8:0]         req_span_start,
   input  logic [9:0]         req_span_end,
   input  logic [15:0]        req_slice_height,
   input  logic [9:0]         req_screen_col,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_out_col,
   output logic [8:0]         rsp_out_row,
   output logic [1:0]         rsp_texture_select,
   output logic [5:0]         rsp_texel_col,
   output logic [5:0]         rsp_texel_row,
   output logic               rsp_last_of_column
);

   // The controller sees only the handshakes and two status bits; all
   // arithmetic and column state lives in the datapath.
   cmd_type    cmd;
   status_type status;

   rwtc_ctrl #(
      .TEX_SIZE (TEX_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath computes the texel column combinationally as a column
   // opens, then runs the restoring divide for the row step and forms the
   // start position from the row offset times that step.
   rwtc_datapath #(
      .TEX_SIZE (TEX_SIZE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_hit_side       (req_hit_side),
      .req_dir_x          (req_dir_x),
      .req_dir_y          (req_dir_y),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_wall_dist      (req_wall_dist),
      .req_span_start     (req_span_start),
      .req_span_end       (req_span_end),
      .req_slice_height   (req_slice_height),
      .req_screen_col     (req_screen_col),
      .rsp_valid          (rsp_valid),
      .rsp_out_col        (rsp_out_col),
      .rsp_out_row        (rsp_out_row),
      .rsp_texture_select (rsp_texture_select),
      .rsp_texel_col      (rsp_texel_col),
      .rsp_texel_row      (rsp_texel_row),
      .rsp_last_of_column (rsp_last_of_column)
   );

endmodule

>>> rtl/rwtc_ctrl.sv
// Controller of the wall texture column block: sequences the divide and the
// start-position multiply, and drives the handshakes. Depends on rwtc_pkg.
module rwtc_ctrl
   import rwtc_pkg::*;
#(
   parameter int TEX_SIZE = TEX_SIZE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_stall,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int TEX_W = $clog2(TEX_SIZE);
   localparam int DIV_W = TEX_W + 17;
   localparam int CNT_W = $clog2(DIV_W);

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic req_fire;

   assign req_stall = (state_ff != ST_IDLE) || (status.rsp_full && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_opcode == OP_BEGIN) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_POSITION;
            end
         end
         ST_POSITION: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_IDLE) begin
         cnt_in = CNT_W'(DIV_W - 1);
      end else if (state_ff == ST_DIVIDE) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.pos_load = 1'b0;
      cmd.emit     = 1'b0;
      cmd.rsp_pop  = status.rsp_full && !rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_fire && (req_opcode == OP_BEGIN);
            cmd.emit = req_fire && (req_opcode == OP_STEP) && status.active;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_POSITION: begin
            cmd.pos_load = 1'b1;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/rwtc_datapath.sv
// Datapath of the wall texture column block: texture column, bit-serial step
// divider, start position multiply, row walk and output register. Uses rwtc_pkg.
module rwtc_datapath
   import rwtc_pkg::*;
#(
   parameter int TEX_SIZE = TEX_SIZE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                req_hit_side,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic [15:0]         req_pos_x,
   input  logic [15:0]         req_pos_y,
   input  logic [15:0]         req_wall_dist,
   input  logic [8:0]          req_span_start,
   input  logic [9:0]          req_span_end,
   input  logic [15:0]         req_slice_height,
   input  logic [9:0]          req_screen_col,
   output logic                rsp_valid,
   output logic [9:0]          rsp_out_col,
   output logic [8:0]          rsp_out_row,
   output logic [1:0]          rsp_texture_select,
   output logic [5:0]          rsp_texel_col,
   output logic [5:0]          rsp_texel_row,
   output logic                rsp_last_of_column
);

   localparam int TEX_W = $clog2(TEX_SIZE);
   localparam int DIV_W = TEX_W + 17;
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TEX_SIZE) << 16;
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(SCREEN_HEIGHT);

   // Column geometry computed when a column opens.
   logic signed [15:0] along;
   logic [15:0]        base;
   logic signed [32:0] hit_prod;
   logic [19:0]        frac;
   logic [TEX_W-1:0]   tx_raw, tx_fin;
   logic [1:0]         sel;
   logic               mirror;
   logic [15:0]        h_adj;
   logic [OFF_W-1:0]   off;
   logic [ROW_W-1:0]   end_sat;

   // Stored state.
   logic                    active_ff, active_in;
   logic [ROW_W-1:0]        cur_row_ff, end_row_ff;
   logic [9:0]              held_col_ff;
   logic [5:0]              held_texel_col_ff;
   logic [1:0]              held_select_ff;
   logic [31:0]             tex_pos_ff, tex_step_ff;
   logic signed [OFF_W-1:0] off_ff;
   logic [15:0]             divisor_ff;
   logic [DIV_W-1:0]        quot_ff;
   logic [16:0]             rem_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Divider iteration.
   logic [16:0] rem_sh;
   logic        rem_ge;

   // Start position product.
   logic signed [OFF_W+DIV_W:0] pos_prod;

   // Pixel walk.
   logic [ROW_W-1:0] row_next;
   logic             row_last;

   always_comb begin
      along    = (req_hit_side == SIDE_Y) ? req_dir_x : req_dir_y;
      base     = (req_hit_side == SIDE_Y) ? req_pos_y : req_pos_x;
      hit_prod = $signed({1'b0, req_wall_dist}) * along;
      // Only the fraction of the hit coordinate is needed, so the sum runs mod 2^20.
      frac     = {base[7:0], 12'd0} + hit_prod[19:0];
      tx_raw   = frac[19 -: TEX_W];

      if (req_hit_side == SIDE_X && req_dir_x > 0) begin
         sel    = TEX_SOUTH;
         mirror = 1'b1;
      end else if (req_hit_side == SIDE_X && req_dir_x < 0) begin
         sel    = TEX_NORTH;
         mirror = 1'b0;
      end else if (req_hit_side == SIDE_Y && req_dir_y < 0) begin
         sel    = TEX_WEST;
         mirror = 1'b1;
      end else begin
         sel    = TEX_EAST;
         mirror = 1'b0;
      end
      // Mirroring TEX_SIZE - tx - 1 is the bitwise complement of tx.
      tx_fin = mirror ? ~tx_raw : tx_raw;

      h_adj   = (req_slice_height == 16'd0) ? 16'd1 : req_slice_height;
      off     = OFF_W'(req_span_start) - OFF_W'(SCREEN_HEIGHT / 2)
                + OFF_W'(h_adj[15:1]);
      end_sat = (32'(req_span_end) > 32'(SCREEN_HEIGHT)) ? ROW_LIMIT : req_span_end;
   end

   always_comb begin
      rem_sh = {rem_ff[15:0], quot_ff[DIV_W-1]};
      rem_ge = rem_sh >= {1'b0, divisor_ff};
   end

   assign pos_prod = off_ff * $signed({1'b0, quot_ff});

   assign row_next = cur_row_ff + ROW_W'(1);
   assign row_last = row_next >= end_row_ff;

   always_comb begin
      active_in = active_ff;
      if (cmd.load) begin
         active_in = {1'b0, req_span_start} < end_sat;
      end else if (cmd.emit && row_last) begin
         active_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_row_ff        <= ROW_W'(req_span_start);
         end_row_ff        <= end_sat;
         held_col_ff       <= req_screen_col;
         held_texel_col_ff <= 6'(tx_fin);
         held_select_ff    <= sel;
         off_ff            <= $signed(off);
         divisor_ff        <= h_adj;
         quot_ff           <= DIVIDEND;
         rem_ff            <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[DIV_W-2:0], rem_ge};
         rem_ff  <= rem_ge ? (rem_sh - {1'b0, divisor_ff}) : rem_sh;
      end else if (cmd.pos_load) begin
         tex_step_ff <= 32'(quot_ff);
         tex_pos_ff  <= pos_prod[31:0];
      end else if (cmd.emit) begin
         cur_row_ff <= row_next;
         tex_pos_ff <= tex_pos_ff + tex_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_col        <= held_col_ff;
         rsp_out_row        <= cur_row_ff[8:0];
         rsp_texture_select <= held_select_ff;
         rsp_texel_col      <= held_texel_col_ff;
         rsp_texel_row      <= 6'(tex_pos_ff[16 +: TEX_W]);
         rsp_last_of_column <= row_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.active   = active_ff;
   assign status.rsp_full = rsp_valid_ff;

endmodule

>>> rtl/rwtc_checker.sv
// Port-level checker of the wall texture column block, bound to the top level.
// Depends on rwtc_pkg and raycast_wall_texture_column_macros.svh.
`include "raycast_wall_texture_column_macros.svh"

module rwtc_checker
   import rwtc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [8:0] rsp_out_row
);

   logic begin_fire;
   assign begin_fire = req_valid && !req_stall && (req_opcode == OP_BEGIN);

   // A stalled item stays offered and keeps its row.
   `RWTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `RWTC_ASSERT_NEXT(a_rsp_row_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_row))

   // Opening a column starts the divide, which holds off the input.
   `RWTC_ASSERT_NEXT(a_begin_busy, clock, reset, begin_fire, req_stall)

   // Opening a column never produces a pixel of its own.
   `RWTC_ASSERT_NEXT(a_begin_silent, clock, reset, begin_fire, !$rose(rsp_valid))

endmodule

bind raycast_wall_texture_column rwtc_checker u_rwtc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_opcode  (req_opcode),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_row (rsp_out_row)
);
